FILE: rtl/bnw_pkg.sv
package bnw_pkg;

	localparam int INDEX_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int POS_BITS   = INDEX_BITS + FRAC_BITS;
	localparam int W_BITS     = FRAC_BITS + 1;
	localparam int CFG_INDEX_BITS = 4;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_COL_COUNT = CFG_INDEX_BITS'(1);

	typedef struct packed {
		logic signed [POS_BITS-1:0] row_pos;
		logic signed [POS_BITS-1:0] col_pos;
	} bnw_in_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] nearest_row;
		logic [INDEX_BITS-1:0] nearest_col;
		logic [INDEX_BITS-1:0] row_low;
		logic [INDEX_BITS-1:0] row_high;
		logic [INDEX_BITS-1:0] col_low;
		logic [INDEX_BITS-1:0] col_high;
		logic [W_BITS-1:0]     weight_ll;
		logic [W_BITS-1:0]     weight_lh;
		logic [W_BITS-1:0]     weight_hl;
		logic [W_BITS-1:0]     weight_hh;
	} bnw_out_t;

endpackage

FILE: rtl/bnw_axis.sv
module bnw_axis
	import bnw_pkg::*;
#(
	parameter int INDEX_W = INDEX_BITS,
	parameter int FRAC_W  = FRAC_BITS
) (
	input  logic signed [INDEX_W+FRAC_W-1:0] pos,
	input  logic [INDEX_W-1:0]               count,
	output logic [INDEX_W-1:0]               nearest,
	output logic [INDEX_W-1:0]               lo,
	output logic [INDEX_W-1:0]               hi,
	output logic [FRAC_W:0]                  sub_hi,
	output logic [FRAC_W:0]                  sub_lo
);

	localparam int PW = INDEX_W + FRAC_W;
	localparam logic [PW-1:0]     HALF_P = PW'(1) << (FRAC_W - 1);
	localparam logic [FRAC_W:0]   HALF_W = (FRAC_W + 1)'(1) << (FRAC_W - 1);
	localparam logic [FRAC_W:0]   ONE_W  = (FRAC_W + 1)'(1) << FRAC_W;

	logic [INDEX_W-1:0] last;
	logic [PW-1:0]      pos_u;
	logic [PW-1:0]      rsum;
	logic [INDEX_W-1:0] rnd;
	logic [PW-1:0]      last_pos;
	logic               neg;
	logic               zero;
	logic               interior;
	logic               frac_nz;
	logic               split;

	always_comb begin
		pos_u    = pos;
		last     = (count == '0) ? '0 : count - INDEX_W'(1);
		neg      = pos_u[PW-1];
		zero     = (pos_u == '0);
		rsum     = pos_u + HALF_P;
		rnd      = rsum[PW-1:FRAC_W];
		last_pos = {last, {FRAC_W{1'b0}}};
		interior = !neg && !zero && (pos_u < last_pos);
		frac_nz  = (pos_u[FRAC_W-1:0] != '0);
		split    = interior && frac_nz;

		if (neg) begin
			nearest = '0;
		end else if (rnd > last) begin
			nearest = last;
		end else begin
			nearest = rnd;
		end

		if (interior) begin
			lo = pos_u[PW-1:FRAC_W];
		end else if (!neg && !zero) begin
			lo = last;
		end else begin
			lo = '0;
		end
		hi = lo + INDEX_W'(split);

		sub_hi = split ? {1'b0, pos_u[FRAC_W-1:0]} : HALF_W;
		sub_lo = ONE_W - sub_hi;
	end

endmodule

FILE: rtl/bilinear_neighbor_weight_gen.sv
// Bilinear neighbor and weight generator.
// Input channel pos/pos_valid/pos_stall: one beat carries a row and column
// position in signed Q16.16. A beat is taken when pos_valid is high and
// pos_stall is low.
// Output channel result/result_valid/result_stall: one beat per input beat,
// holding nearest indices, bracketing indices and four Q1.16 weights.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data: index 0 writes
// row_count, index 1 col_count, other indices are ignored. cfg_ready is
// always high; write only while no beat is in flight.
// Stages: axis resolve (s1), four 17x17 multiplies (s2), rounding (s3); a
// beat is registered in each on its way to result_valid. One beat per cycle
// is sustained except when result_stall is high with a result waiting: then
// the whole pipeline freezes and pos_stall is raised; nothing is dropped or
// repeated. Reset clears all valid bits and sets both counts to 1.
module bilinear_neighbor_weight_gen
	import bnw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pos_valid,
	output logic                      pos_stall,
	input  bnw_in_t                   pos,
	output logic                      result_valid,
	input  logic                      result_stall,
	output bnw_out_t                  result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [INDEX_BITS-1:0]     cfg_data
);

	localparam int PROD_BITS = 2 * W_BITS;
	localparam logic [PROD_BITS-1:0] HALF_PROD = PROD_BITS'(1) << (FRAC_BITS - 1);

	logic [INDEX_BITS-1:0] row_count_q, col_count_q;

	logic adv;
	logic valid_s1, valid_s2, valid_s3;

	logic [INDEX_BITS-1:0] nr_c, nc_c, rl_c, rh_c, cl_c, ch_c;
	logic [W_BITS-1:0]     r2_c, r1_c, c2_c, c1_c;

	logic [INDEX_BITS-1:0] nr_s1, nc_s1, rl_s1, rh_s1, cl_s1, ch_s1;
	logic [W_BITS-1:0]     r2_s1, r1_s1, c2_s1, c1_s1;

	logic [INDEX_BITS-1:0]  nr_s2, nc_s2, rl_s2, rh_s2, cl_s2, ch_s2;
	logic [PROD_BITS-1:0]   pll_s2, plh_s2, phl_s2, phh_s2;

	bnw_out_t res_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= INDEX_BITS'(1);
			col_count_q <= INDEX_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW_COUNT: row_count_q <= cfg_data;
				CFG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bnw_axis #(.INDEX_W(INDEX_BITS), .FRAC_W(FRAC_BITS)) u_row (
		.pos     (pos.row_pos),
		.count   (row_count_q),
		.nearest (nr_c),
		.lo      (rl_c),
		.hi      (rh_c),
		.sub_hi  (r2_c),
		.sub_lo  (r1_c)
	);

	bnw_axis #(.INDEX_W(INDEX_BITS), .FRAC_W(FRAC_BITS)) u_col (
		.pos     (pos.col_pos),
		.count   (col_count_q),
		.nearest (nc_c),
		.lo      (cl_c),
		.hi      (ch_c),
		.sub_hi  (c2_c),
		.sub_lo  (c1_c)
	);

	assign adv       = !(valid_s3 && result_stall);
	assign pos_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pos_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nr_s1 <= nr_c;
			nc_s1 <= nc_c;
			rl_s1 <= rl_c;
			rh_s1 <= rh_c;
			cl_s1 <= cl_c;
			ch_s1 <= ch_c;
			r2_s1 <= r2_c;
			r1_s1 <= r1_c;
			c2_s1 <= c2_c;
			c1_s1 <= c1_c;

			nr_s2  <= nr_s1;
			nc_s2  <= nc_s1;
			rl_s2  <= rl_s1;
			rh_s2  <= rh_s1;
			cl_s2  <= cl_s1;
			ch_s2  <= ch_s1;
			pll_s2 <= PROD_BITS'(r1_s1) * PROD_BITS'(c1_s1);
			plh_s2 <= PROD_BITS'(r1_s1) * PROD_BITS'(c2_s1);
			phl_s2 <= PROD_BITS'(r2_s1) * PROD_BITS'(c1_s1);
			phh_s2 <= PROD_BITS'(r2_s1) * PROD_BITS'(c2_s1);

			res_s3.nearest_row <= nr_s2;
			res_s3.nearest_col <= nc_s2;
			res_s3.row_low     <= rl_s2;
			res_s3.row_high    <= rh_s2;
			res_s3.col_low     <= cl_s2;
			res_s3.col_high    <= ch_s2;
			res_s3.weight_ll   <= W_BITS'((pll_s2 + HALF_PROD) >> FRAC_BITS);
			res_s3.weight_lh   <= W_BITS'((plh_s2 + HALF_PROD) >> FRAC_BITS);
			res_s3.weight_hl   <= W_BITS'((phl_s2 + HALF_PROD) >> FRAC_BITS);
			res_s3.weight_hh   <= W_BITS'((phh_s2 + HALF_PROD) >> FRAC_BITS);
		end
	end

	assign result_valid = valid_s3;
	assign result       = res_s3;

`ifndef SYNTHESIS
	localparam logic [W_BITS-1:0] QUARTER = W_BITS'(1) << (FRAC_BITS - 2);

	a_stall_only_on_waiting_result: assert property (
		@(posedge clk) disable iff (!arst_n)
		pos_stall |-> result_valid
	) else $error("input stalled without a waiting result");

	a_row_bracket: assert property (
		@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.row_high == result.row_low) ||
			(result.row_high == INDEX_BITS'(result.row_low + INDEX_BITS'(1)))
	) else $error("row bracket not adjacent");

	a_col_bracket: assert property (
		@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.col_high == result.col_low) ||
			(result.col_high == INDEX_BITS'(result.col_low + INDEX_BITS'(1)))
	) else $error("column bracket not adjacent");

	a_even_split: assert property (
		@(posedge clk) disable iff (!arst_n)
		(result_valid && result.row_low == result.row_high &&
			result.col_low == result.col_high) |->
		(result.weight_ll == QUARTER && result.weight_lh == QUARTER &&
			result.weight_hl == QUARTER && result.weight_hh == QUARTER)
	) else $error("collapsed brackets without even split");
`endif

endmodule
